// ===== hdl/ljpe_pkg.sv =====
package ljpe_pkg;

   localparam int COORD_W  = 32;
   localparam int ENERGY_W = 48;
   localparam int EPS_W    = 32;
   localparam int CUT_W    = 24;
   localparam int APB_AW   = 3;
   localparam int APB_DW   = 32;

   // Register select, taken from the word-aligned address bit.
   localparam logic REG_WELL_DEPTH    = 1'b0;
   localparam logic REG_CUTOFF_FACTOR = 1'b1;

   localparam logic [EPS_W-1:0] WELL_DEPTH_RST    = 32'd65536;
   localparam logic [CUT_W-1:0] CUTOFF_FACTOR_RST = 24'd82570;

   localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

   // Side information that follows an item down the back half of the pipe.
   typedef struct packed {
      logic        in_range;
      logic        zero;
      logic        big;
      logic [63:0] q;
   } side_type;

endpackage

// ===== hdl/ljpe_req_if.sv =====
interface ljpe_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] first_x;
   logic signed [31:0] first_y;
   logic signed [31:0] first_z;
   logic signed [31:0] second_x;
   logic signed [31:0] second_y;
   logic signed [31:0] second_z;
   logic        [31:0] diameter;

   modport source (output valid, first_x, first_y, first_z, second_x, second_y,
                   second_z, diameter, input ready);
   modport sink (input valid, first_x, first_y, first_z, second_x, second_y,
                 second_z, diameter, output ready);
endinterface

// ===== hdl/ljpe_rsp_if.sv =====
interface ljpe_rsp_if;
   logic        valid;
   logic        ready;
   logic [47:0] energy;
   logic        inside_cutoff;
   logic        saturated;

   modport source (output valid, energy, inside_cutoff, saturated, input ready);
   modport sink (input valid, energy, inside_cutoff, saturated, output ready);
endinterface

// ===== hdl/lj_pair_energy.sv =====
// Each accepted input word passes through every stage to one result word (Q32.16 at FRAC_BITS = 16).
// Throughput: one pair per cycle; the pipeline advances as a whole whenever its output
// register is empty or the result word is being taken.
// Reset (synchronous, active high) empties every pipeline stage and loads the registers
// with well_depth = 1.0 and cutoff_factor = 82570 (about 2^(1/3)).
module lj_pair_energy #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   ljpe_req_if.sink                    req_chan,
   ljpe_rsp_if.source                  rsp_chan,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [ljpe_pkg::APB_AW-1:0] csr_paddr,
   input  logic [ljpe_pkg::APB_DW-1:0] csr_pwdata,
   output logic [ljpe_pkg::APB_DW-1:0] csr_prdata,
   output logic                        csr_pready
);
   import ljpe_pkg::*;

   localparam int QW    = 64 + FRAC_BITS;
   localparam int CMP_W = (66 + FRAC_BITS > 88) ? 66 + FRAC_BITS : 88;

   // ------------------------------------------------------------------
   // Configuration registers. The APB port never waits; a write lands at
   // the access phase. Address bit 2 selects the register.
   // ------------------------------------------------------------------
   logic [EPS_W-1:0] well_depth_ff;
   logic [CUT_W-1:0] cutoff_factor_ff;
   logic             csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         well_depth_ff    <= WELL_DEPTH_RST;
         cutoff_factor_ff <= CUTOFF_FACTOR_RST;
      end else if (csr_wr) begin
         case (csr_paddr[2])
            REG_WELL_DEPTH:    well_depth_ff    <= csr_pwdata[EPS_W-1:0];
            REG_CUTOFF_FACTOR: cutoff_factor_ff <= csr_pwdata[CUT_W-1:0];
            default:           well_depth_ff    <= well_depth_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_WELL_DEPTH:    csr_prdata = well_depth_ff;
         REG_CUTOFF_FACTOR: csr_prdata = {{(APB_DW-CUT_W){1'b0}}, cutoff_factor_ff};
         default:           csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Flow control. Every stage moves together; the final stage is the
   // output register, so a new word enters while a finished result waits
   // only if that result is leaving in the same cycle.
   // ------------------------------------------------------------------
   logic out_vld_ff;
   logic en;

   assign en             = !out_vld_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   // Stage 1: absolute coordinate differences (33-bit magnitudes).
   logic        s1_vld_ff;
   logic [32:0] s1_dx_ff, s1_dy_ff, s1_dz_ff;
   logic [31:0] s1_d_ff;

   function automatic logic [32:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] diff;
      diff = {a[31], a} - {b[31], b};
      return diff[32] ? 33'(-diff) : diff;
   endfunction

   always_ff @(posedge clock) begin
      if (en) begin
         s1_dx_ff <= abs_diff(req_chan.first_x, req_chan.second_x);
         s1_dy_ff <= abs_diff(req_chan.first_y, req_chan.second_y);
         s1_dz_ff <= abs_diff(req_chan.first_z, req_chan.second_z);
         s1_d_ff  <= req_chan.diameter;
      end
   end

   // Stage 2: the three squares and the squared diameter, one multiplier per lane.
   logic        s2_vld_ff;
   logic [65:0] s2_sx_ff, s2_sy_ff, s2_sz_ff;
   logic [63:0] s2_d2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s2_sx_ff <= s1_dx_ff * s1_dx_ff;
         s2_sy_ff <= s1_dy_ff * s1_dy_ff;
         s2_sz_ff <= s1_dz_ff * s1_dz_ff;
         s2_d2_ff <= s1_d_ff * s1_d_ff;
      end
   end

   // Stage 3: r2 is the exact sum of squares; the cutoff product is split in
   // two 24x32 halves.
   logic        s3_vld_ff;
   logic [65:0] s3_r2_ff;
   logic [63:0] s3_d2_ff;
   logic [55:0] s3_cl_ff, s3_ch_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s3_r2_ff <= s2_sx_ff + s2_sy_ff + s2_sz_ff;
         s3_d2_ff <= s2_d2_ff;
         s3_cl_ff <= cutoff_factor_ff * s2_d2_ff[31:0];
         s3_ch_ff <= cutoff_factor_ff * s2_d2_ff[63:32];
      end
   end

   // Stage 4: exact cutoff compare and zero-separation detect.
   logic        s4_vld_ff;
   logic [65:0] s4_r2_ff;
   logic [63:0] s4_d2_ff;
   side_type    s4_side_ff;
   logic [CMP_W-1:0] cmp_lhs, cmp_rhs;
   side_type    s4_side_in;

   always_comb begin
      cmp_lhs = CMP_W'(s3_r2_ff) << FRAC_BITS;
      cmp_rhs = CMP_W'(s3_cl_ff) + (CMP_W'(s3_ch_ff) << 32);
      s4_side_in.in_range = (cmp_lhs < cmp_rhs);
      s4_side_in.zero     = (s3_r2_ff == '0);
      s4_side_in.big      = 1'b0;
      s4_side_in.q        = '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_r2_ff   <= s3_r2_ff;
         s4_d2_ff   <= s3_d2_ff;
         s4_side_ff <= s4_side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_chan.valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
   end

   // Division q = floor(d2 * 2^F / r2), one quotient bit per stage. A zero
   // separation gives a meaningless quotient, which the final stage overrides.
   logic          dv_vld;
   logic [QW-1:0] dv_quo;
   side_type      dv_side, m1_side_in;

   ljpe_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (s4_vld_ff),
      .num      (s4_d2_ff),
      .den      (s4_r2_ff),
      .side_in  (s4_side_ff),
      .out_vld  (dv_vld),
      .quo      (dv_quo),
      .side_out (dv_side)
   );

   // A quotient that does not fit 64 bits marks the item as overflowed.
   always_comb begin
      m1_side_in     = dv_side;
      m1_side_in.q   = dv_quo[63:0];
      m1_side_in.big = |dv_quo[QW-1:64];
   end

   // q^2, then q^3: two multiply-and-shift units in a row.
   logic        m1_vld, m2_vld;
   logic [63:0] m1_p, m2_p;
   side_type    m1_side, m2_side;

   ljpe_mulsh #(.FRAC_BITS(FRAC_BITS)) u_mul_qq (
      .clock (clock), .reset (reset), .en (en),
      .in_vld (dv_vld), .a (dv_quo[63:0]), .b (dv_quo[63:0]), .side_in (m1_side_in),
      .out_vld (m1_vld), .p (m1_p), .side_out (m1_side)
   );

   ljpe_mulsh #(.FRAC_BITS(FRAC_BITS)) u_mul_qqq (
      .clock (clock), .reset (reset), .en (en),
      .in_vld (m1_vld), .a (m1_p), .b (m1_side.q), .side_in (m1_side),
      .out_vld (m2_vld), .p (m2_p), .side_out (m2_side)
   );

   // Stage T: t = |2s - 1|. The energy 4*eps*s*(s-1)+eps equals eps*(2s-1)^2.
   logic        st_vld_ff;
   logic [63:0] st_t_ff;
   side_type    st_side_ff, st_side_in;
   logic [63:0] two_s, one_fx, t_in;

   always_comb begin
      two_s          = {m2_p[62:0], 1'b0};
      one_fx         = 64'd1 << FRAC_BITS;
      t_in           = (two_s >= one_fx) ? two_s - one_fx : one_fx - two_s;
      st_side_in     = m2_side;
      st_side_in.big = m2_side.big | m2_p[63];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_t_ff    <= t_in;
         st_side_ff <= st_side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_vld_ff <= 1'b0;
      end else if (en) begin
         st_vld_ff <= m2_vld;
      end
   end

   // t^2, then t^2 * eps.
   logic        m3_vld, m4_vld;
   logic [63:0] m3_p, m4_p;
   side_type    m3_side, m4_side;

   ljpe_mulsh #(.FRAC_BITS(FRAC_BITS)) u_mul_tt (
      .clock (clock), .reset (reset), .en (en),
      .in_vld (st_vld_ff), .a (st_t_ff), .b (st_t_ff), .side_in (st_side_ff),
      .out_vld (m3_vld), .p (m3_p), .side_out (m3_side)
   );

   ljpe_mulsh #(.FRAC_BITS(FRAC_BITS)) u_mul_eps (
      .clock (clock), .reset (reset), .en (en),
      .in_vld (m3_vld), .a (m3_p), .b ({32'b0, well_depth_ff}), .side_in (m3_side),
      .out_vld (m4_vld), .p (m4_p), .side_out (m4_side)
   );

   // Output register. Outside the cutoff everything is zero; a zero
   // separation inside it saturates whatever the well depth; a zero well
   // depth gives zero energy; any overflow on the way saturates.
   logic [ENERGY_W-1:0] energy_ff, energy_in;
   logic                inside_ff, sat_ff, sat_in;

   always_comb begin
      energy_in = '0;
      sat_in    = 1'b0;
      if (m4_side.in_range) begin
         if (m4_side.zero) begin
            energy_in = ENERGY_MAX;
            sat_in    = 1'b1;
         end else if (well_depth_ff != '0) begin
            if (m4_side.big || (|m4_p[63:ENERGY_W])) begin
               energy_in = ENERGY_MAX;
               sat_in    = 1'b1;
            end else begin
               energy_in = m4_p[ENERGY_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         energy_ff <= energy_in;
         inside_ff <= m4_side.in_range;
         sat_ff    <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= m4_vld;
      end
   end

   assign rsp_chan.valid         = out_vld_ff;
   assign rsp_chan.energy        = energy_ff;
   assign rsp_chan.inside_cutoff = inside_ff;
   assign rsp_chan.saturated     = sat_ff;

endmodule

// ===== hdl/ljpe_div.sv =====
module ljpe_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_vld,
   input  logic [63:0]               num,
   input  logic [65:0]               den,
   input  ljpe_pkg::side_type        side_in,
   output logic                      out_vld,
   output logic [64+FRAC_BITS-1:0]   quo,
   output ljpe_pkg::side_type        side_out
);
   import ljpe_pkg::*;

   localparam int QW = 64 + FRAC_BITS;

   logic            vld_ff  [QW];
   logic [65:0]     rem_ff  [QW];
   logic [QW-1:0]   quo_ff  [QW];
   logic [65:0]     den_ff  [QW];
   logic [63:0]     num_ff  [QW];
   side_type        side_ff [QW];

   // One quotient bit per stage, most significant first.
   for (genvar g = 0; g < QW; g++) begin : g_stage
      localparam int J = QW - 1 - g;
      logic            vld_prev;
      logic [65:0]     rem_prev;
      logic [QW-1:0]   quo_prev;
      logic [65:0]     den_prev;
      logic [63:0]     num_prev;
      side_type        side_prev;
      logic            nbit;
      logic [66:0]     trial;
      logic            take;
      logic [65:0]     rem_in;
      logic [QW-1:0]   quo_in;

      if (g == 0) begin : g_first
         assign vld_prev  = in_vld;
         assign rem_prev  = '0;
         assign quo_prev  = '0;
         assign den_prev  = den;
         assign num_prev  = num;
         assign side_prev = side_in;
      end else begin : g_next
         assign vld_prev  = vld_ff[g-1];
         assign rem_prev  = rem_ff[g-1];
         assign quo_prev  = quo_ff[g-1];
         assign den_prev  = den_ff[g-1];
         assign num_prev  = num_ff[g-1];
         assign side_prev = side_ff[g-1];
      end

      if (J >= FRAC_BITS) begin : g_nbit
         assign nbit = num_prev[J-FRAC_BITS];
      end else begin : g_zbit
         assign nbit = 1'b0;
      end

      always_comb begin
         trial  = {rem_prev, nbit};
         take   = (trial >= {1'b0, den_prev});
         rem_in = take ? 66'(trial - {1'b0, den_prev}) : trial[65:0];
         quo_in = {quo_prev[QW-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (en) begin
            vld_ff[g] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g]  <= rem_in;
            quo_ff[g]  <= quo_in;
            den_ff[g]  <= den_prev;
            num_ff[g]  <= num_prev;
            side_ff[g] <= side_prev;
         end
      end
   end

   assign out_vld  = vld_ff[QW-1];
   assign quo      = quo_ff[QW-1];
   assign side_out = side_ff[QW-1];

endmodule

// ===== hdl/ljpe_mulsh.sv =====
module ljpe_mulsh #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_vld,
   input  logic [63:0]        a,
   input  logic [63:0]        b,
   input  ljpe_pkg::side_type side_in,
   output logic               out_vld,
   output logic [63:0]        p,
   output ljpe_pkg::side_type side_out
);
   import ljpe_pkg::*;

   logic        vld_a_ff, vld_b_ff;
   logic [63:0] p00_ff, p01_ff, p10_ff, p11_ff;
   side_type    side_a_ff, side_b_ff;
   logic [63:0] p_ff;
   logic [64:0] mid;
   logic [127:0] full, shifted;
   side_type    side_b_in;

   // Four 32x32 partial products, then one sum with the fixed-point shift.
   always_ff @(posedge clock) begin
      if (en) begin
         p00_ff    <= a[31:0]  * b[31:0];
         p01_ff    <= a[31:0]  * b[63:32];
         p10_ff    <= a[63:32] * b[31:0];
         p11_ff    <= a[63:32] * b[63:32];
         side_a_ff <= side_in;
      end
   end

   always_comb begin
      mid       = {1'b0, p01_ff} + {1'b0, p10_ff};
      full      = {p11_ff, p00_ff} + ({63'b0, mid} << 32);
      shifted   = full >> FRAC_BITS;
      side_b_in = side_a_ff;
      side_b_in.big = side_a_ff.big | (|shifted[127:64]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff      <= shifted[63:0];
         side_b_ff <= side_b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
      end else if (en) begin
         vld_a_ff <= in_vld;
         vld_b_ff <= vld_a_ff;
      end
   end

   assign out_vld  = vld_b_ff;
   assign p        = p_ff;
   assign side_out = side_b_ff;

endmodule

// ===== tb/sv/tb_lj_pair_energy.sv =====
module tb_lj_pair_energy;
   import ljpe_pkg::*;

   // Byte addresses of the two registers; each one sits on its own 32-bit word.
   localparam logic [APB_AW-1:0] ADDR_WELL_DEPTH    = 3'd0;
   localparam logic [APB_AW-1:0] ADDR_CUTOFF_FACTOR = 3'd4;

   // Pipeline depth from input word to result word at Q16.16, and a drain wait with a margin on top.
   localparam int PIPE_DEPTH  = 94;
   localparam int DRAIN_WAIT  = PIPE_DEPTH + 30;
   localparam int STALL_LIMIT = 5000;
   localparam int PHASES      = 8;
   localparam int RANDOM_ITEMS = 1720;

   typedef struct {
      logic [COORD_W-1:0] first_x, first_y, first_z;
      logic [COORD_W-1:0] second_x, second_y, second_z;
      logic [31:0]        diameter;
   } pair_type;

   typedef struct {
      logic [ENERGY_W-1:0] energy;
      logic                inside_cutoff;
      logic                saturated;
   } energy_type;

   // The scoreboard predicts the WCA energy of every accepted pair and checks
   // result words against those predictions in order.
   class energy_board;
      logic [EPS_W-1:0] well_depth = WELL_DEPTH_RST;
      logic [CUT_W-1:0] cutoff     = CUTOFF_FACTOR_RST;
      energy_type       pending[$];
      int               mismatches = 0;

      function logic [32:0] abs_gap(logic [31:0] a, logic [31:0] b);
         logic signed [32:0] df;
         df = $signed({a[31], a}) - $signed({b[31], b});
         return df[32] ? 33'(-df) : 33'(df);
      endfunction

      function logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, inout bit big);
         logic [127:0] p;
         p = (128'(a) * 128'(b)) >> 16;
         if (p[127:64] != 0) big = 1;
         return p[63:0];
      endfunction

      function void note_pair(pair_type p);
         logic [127:0] r2, g, lim, q;
         logic [63:0]  d2, qq, s, t, t2, e;
         bit           big;
         energy_type   x;
         r2 = 0;
         big = 0;
         g = 128'(abs_gap(p.first_x, p.second_x)); r2 += g * g;
         g = 128'(abs_gap(p.first_y, p.second_y)); r2 += g * g;
         g = 128'(abs_gap(p.first_z, p.second_z)); r2 += g * g;
         d2 = 64'(p.diameter) * 64'(p.diameter);
         lim = 128'(cutoff) * 128'(d2);
         x.energy = 0;
         x.saturated = 0;
         x.inside_cutoff = (r2 << 16) < lim;
         if (x.inside_cutoff && r2 == 0) begin
            x.energy = ENERGY_MAX;
            x.saturated = 1;
         end else if (x.inside_cutoff && well_depth != 0) begin
            q = (128'(d2) << 16) / r2;
            if (q[127:64] != 0) big = 1;
            qq = q[63:0];
            s = mul_shift(mul_shift(qq, qq, big), qq, big);
            if (s[63]) big = 1;
            s = s << 1;
            t = (s >= 64'h10000) ? s - 64'h10000 : 64'h10000 - s;
            t2 = mul_shift(t, t, big);
            e = mul_shift(t2, 64'(well_depth), big);
            if (e > 64'(ENERGY_MAX)) big = 1;
            if (big) begin
               x.energy = ENERGY_MAX;
               x.saturated = 1;
            end else begin
               x.energy = e[ENERGY_W-1:0];
            end
         end
         pending.push_back(x);
      endfunction

      function void check_energy(energy_type got);
         energy_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result word with nothing expected: energy %h", got.energy);
            return;
         end
         want = pending.pop_front();
         if (got.energy !== want.energy || got.inside_cutoff !== want.inside_cutoff ||
             got.saturated !== want.saturated) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected energy %h inside %b sat %b, got %h %b %b",
                        want.energy, want.inside_cutoff, want.saturated,
                        got.energy, got.inside_cutoff, got.saturated);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset;
   logic              csr_psel, csr_penable, csr_pwrite;
   logic [APB_AW-1:0] csr_paddr;
   logic [APB_DW-1:0] csr_pwdata, csr_prdata;
   logic              csr_pready;

   ljpe_req_if req();
   ljpe_rsp_if rsp();

   energy_board board = new();

   // Chance in percent that the sender idles before a pair, and percentage of cycles in which the receiver stalls.
   int idle_pct  = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;

   always #5 clock = ~clock;

   lj_pair_energy dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req),
      .rsp_chan    (rsp),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // The receiver drops ready at random; a stall percentage of zero keeps it high.
   always @(posedge clock) begin
      rsp.ready <= !reset && ($urandom_range(99) >= stall_pct);
   end

   // Words are sampled at the same edge that moves them, before any driver update
   // lands, so the scoreboard sees exactly what the block saw. The watchdog counts
   // cycles in which neither channel moves a word.
   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready) begin
            board.note_pair('{req.first_x, req.first_y, req.first_z, req.second_x,
                              req.second_y, req.second_z, req.diameter});
         end
         if (rsp.valid && rsp.ready) begin
            board.check_energy('{rsp.energy, rsp.inside_cutoff, rsp.saturated});
         end
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_lj_pair_energy: errors");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Register write: a setup phase, then an access phase held until pready.
   task automatic write_reg(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
      csr_psel    <= 1;
      csr_penable <= 0;
      csr_pwrite  <= 1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 0;
      csr_penable <= 0;
      csr_pwrite  <= 0;
      if (addr == ADDR_WELL_DEPTH) board.well_depth = data[EPS_W-1:0];
      else board.cutoff = data[CUT_W-1:0];
   endtask

   // Offers one pair, possibly after a short idle gap, and returns at the edge
   // that accepts it. Valid stays high between back-to-back words.
   task automatic send_pair(pair_type p);
      if ($urandom_range(99) < idle_pct) begin
         req.valid <= 0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req.valid    <= 1;
      req.first_x  <= p.first_x;
      req.first_y  <= p.first_y;
      req.first_z  <= p.first_z;
      req.second_x <= p.second_x;
      req.second_y <= p.second_y;
      req.second_z <= p.second_z;
      req.diameter <= p.diameter;
      do @(posedge clock); while (!req.ready);
   endtask

   // Waits until every expected result has arrived and the pipe has emptied.
   task automatic drain();
      req.valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   function automatic pair_type make_pair(int fx, int fy, int fz, int sx, int sy, int sz,
                                          logic [31:0] d);
      pair_type p;
      p = '{fx, fy, fz, sx, sy, sz, d};
      return p;
   endfunction

   // Most random pairs sit near contact so that they land inside the cutoff and
   // exercise the energy path: a random diameter and per-axis offsets bounded by
   // half of it or by all of it. The rest are fully random words.
   function automatic pair_type random_pair();
      pair_type      p;
      longint        off, span;
      logic [31:0]   d;
      p = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      if ($urandom_range(99) < 80) begin
         d = $urandom >> $urandom_range(24, 0);
         span = ($urandom_range(1) == 0) ? longint'(d) / 2 + 1 : longint'(d) + 1;
         off = longint'($signed($urandom)) % span;
         p.second_x = p.first_x + 32'(off);
         off = longint'($signed($urandom)) % span;
         p.second_y = p.first_y + 32'(off);
         off = longint'($signed($urandom)) % span;
         p.second_z = p.first_z + 32'(off);
         p.diameter = d;
      end
      return p;
   endfunction

   initial begin
      pair_type directed[$];
      int       per_phase;
      req.valid    <= 0;
      req.first_x  <= 0;
      req.first_y  <= 0;
      req.first_z  <= 0;
      req.second_x <= 0;
      req.second_y <= 0;
      req.second_z <= 0;
      req.diameter <= 0;
      csr_psel     <= 0;
      csr_penable  <= 0;
      csr_pwrite   <= 0;
      csr_paddr    <= 0;
      csr_pwdata   <= 0;
      reset        <= 1;
      repeat (5) @(posedge clock);
      reset <= 0;

      // A zero diameter is always outside the cutoff.
      directed.push_back(make_pair(0, 0, 0, 0, 0, 0, 0));
      // Coincident bodies inside the cutoff saturate.
      directed.push_back(make_pair(0, 0, 0, 0, 0, 0, 32'h10000));
      directed.push_back(make_pair(-1, 5, 7, -1, 5, 7, 32'hFFFFFFFF));
      directed.push_back(make_pair(32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                                   32'h80000000, 32'h7FFFFFFF, 32'h80000000, 1));
      // Separation equal to the diameter gives exactly epsilon.
      directed.push_back(make_pair(0, 0, 0, 32'h10000, 0, 0, 32'h10000));
      directed.push_back(make_pair(0, 0, 0, 0, 0, 1, 1));
      // Between contact and the cutoff, closer than contact, just beyond the cutoff and far beyond it.
      directed.push_back(make_pair(0, 0, 0, 72090, 0, 0, 32'h10000));
      directed.push_back(make_pair(0, 0, 0, 0, 58982, 0, 32'h10000));
      directed.push_back(make_pair(0, 0, 0, 73600, 0, 0, 32'h10000));
      directed.push_back(make_pair(0, 0, 0, 32'h20000, 0, 0, 32'h10000));
      // A one-LSB separation against a unit diameter overflows.
      directed.push_back(make_pair(0, 0, 0, 1, 0, 0, 32'h10000));
      directed.push_back(make_pair(3, 3, 3, 4, 4, 4, 32'hFFFFFFFF));
      // Widest possible separation, with the largest and a small diameter, then -1 against 0 on each axis.
      directed.push_back(make_pair(32'h80000000, 32'h80000000, 32'h80000000,
                                   32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                   32'hFFFFFFFF));
      directed.push_back(make_pair(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                                   32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h10000));
      directed.push_back(make_pair(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                                   0, 0, 0, 32'hFFFFFFFF));

      per_phase = RANDOM_ITEMS / PHASES;
      for (int ph = 0; ph < PHASES; ph++) begin
         // Registers change only while the pipe is empty.
         case (ph)
            0: begin
               write_reg(ADDR_WELL_DEPTH, WELL_DEPTH_RST);
               write_reg(ADDR_CUTOFF_FACTOR, CUTOFF_FACTOR_RST);
            end
            1: begin
               write_reg(ADDR_WELL_DEPTH, 0);
               write_reg(ADDR_CUTOFF_FACTOR, 24'hFFFFFF);
            end
            2: begin
               write_reg(ADDR_WELL_DEPTH, 32'hFFFFFFFF);
               write_reg(ADDR_CUTOFF_FACTOR, 0);
            end
            3: begin
               write_reg(ADDR_WELL_DEPTH, 32'hFFFFFFFF);
               write_reg(ADDR_CUTOFF_FACTOR, 24'hFFFFFF);
            end
            4: begin
               write_reg(ADDR_WELL_DEPTH, 1);
               write_reg(ADDR_CUTOFF_FACTOR, 24'h10000);
            end
            default: begin
               write_reg(ADDR_WELL_DEPTH, $urandom >> $urandom_range(16));
               write_reg(ADDR_CUTOFF_FACTOR, $urandom_range(24'hFFFFFF));
            end
         endcase
         // Idling modes cycle: none, sender only, receiver only, both.
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 53; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 53; end
            default: begin idle_pct = 32; stall_pct = 32; end
         endcase
         if (ph == 0) begin
            foreach (directed[i]) send_pair(directed[i]);
         end
         for (int n = 0; n < per_phase; n++) send_pair(random_pair());
         drain();
      end

      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("tb_lj_pair_energy: clean");
      end else begin
         $display("tb_lj_pair_energy: errors");
      end
      $finish;
   end

endmodule

// ===== lj_pair_energy.f =====
hdl/ljpe_pkg.sv
hdl/ljpe_req_if.sv
hdl/ljpe_rsp_if.sv
hdl/ljpe_div.sv
hdl/ljpe_mulsh.sv
hdl/lj_pair_energy.sv
tb/sv/tb_lj_pair_energy.sv
